### rtl/core/gpsp_pkg.sv
// ----------------------------------------------------------------------------
// gpsp_pkg
// Shared types, request codes and frame tables for the gamepad poll master.
// ----------------------------------------------------------------------------
package gpsp_pkg;

  localparam int unsigned NUM_CAPTURED = 6;
  localparam int unsigned OUT_DEPTH    = 2;

  typedef logic [2:0] req_t;
  localparam req_t REQ_POLL_TICK    = 3'd0;
  localparam req_t REQ_ENTER_CFG    = 3'd1;
  localparam req_t REQ_EXIT_CFG     = 3'd2;
  localparam req_t REQ_SET_ANALOG   = 3'd3;
  localparam req_t REQ_BIT_SLOT     = 3'd4;
  localparam req_t REQ_RESET_STATUS = 3'd5;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_POLL       = 2'd0;
  localparam kind_t KIND_ENTER_CFG  = 2'd1;
  localparam kind_t KIND_EXIT_CFG   = 2'd2;
  localparam kind_t KIND_SET_ANALOG = 2'd3;

  localparam logic [7:0] BUTTONS_IDLE = 8'hFF;
  localparam logic [7:0] AXIS_CENTER  = 8'd128;
  localparam logic [3:0] FIRST_STORED = 4'd3;
  localparam logic [3:0] LAST_BYTE    = 4'd8;

  typedef logic [NUM_CAPTURED-1:0][7:0] captured_t;

  typedef struct packed {
    logic      att_level;
    logic      cmd_bit;
    logic      busy_res;
    logic      frame_done;
    captured_t captured;
  } result_t;

  function automatic captured_t captured_reset();
    captured_t c;
    c[0] = BUTTONS_IDLE;
    c[1] = BUTTONS_IDLE;
    c[2] = AXIS_CENTER;
    c[3] = AXIS_CENTER;
    c[4] = AXIS_CENTER;
    c[5] = AXIS_CENTER;
    return c;
  endfunction

  function automatic logic [3:0] frame_len(input kind_t kind);
    logic [3:0] len;
    case (kind)
      KIND_ENTER_CFG: len = 4'd5;
      default:        len = 4'd9;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] frame_byte(input kind_t kind, input logic [3:0] idx);
    logic [7:0] b;
    b = 8'h00;
    case (idx)
      4'd0: b = 8'h01;
      4'd1: begin
        case (kind)
          KIND_POLL:       b = 8'h42;
          KIND_SET_ANALOG: b = 8'h44;
          default:         b = 8'h43;
        endcase
      end
      4'd3: begin
        if (kind == KIND_ENTER_CFG || kind == KIND_SET_ANALOG) b = 8'h01;
      end
      4'd4: begin
        case (kind)
          KIND_EXIT_CFG:   b = 8'h5A;
          KIND_SET_ANALOG: b = 8'h03;
          default:         b = 8'h00;
        endcase
      end
      4'd5, 4'd6, 4'd7, 4'd8: begin
        if (kind == KIND_EXIT_CFG) b = 8'h5A;
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### rtl/core/gpsp_frame_engine.sv
// ----------------------------------------------------------------------------
// gpsp_frame_engine
// Frame sequencer: updates link state for each accepted word and forms its result.
// ----------------------------------------------------------------------------
module gpsp_frame_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  gpsp_pkg::req_t      req_type,
  input  logic                data_in,
  input  logic                poll_enable,
  output gpsp_pkg::result_t   result
);

  gpsp_pkg::kind_t     frame_kind, frame_kind_next;
  logic                frame_active, frame_active_next;
  logic [3:0]          byte_index, byte_index_next;
  logic [2:0]          bit_index, bit_index_next;
  logic [7:0]          receive_shift, receive_shift_next;
  gpsp_pkg::captured_t captured, captured_next;

  logic                start;
  gpsp_pkg::kind_t     start_kind;
  logic [3:0]          bi;
  logic [3:0]          bi_inc;
  logic [3:0]          slot;
  logic [7:0]          cur_byte;
  logic                cmd;
  logic                done;

  assign bi       = (byte_index < 4'd9) ? byte_index : gpsp_pkg::LAST_BYTE;
  assign bi_inc   = bi + 4'd1;
  assign slot     = bi - gpsp_pkg::FIRST_STORED;
  assign cur_byte = gpsp_pkg::frame_byte(frame_kind, bi);

  always_comb begin
    frame_kind_next    = frame_kind;
    frame_active_next  = frame_active;
    byte_index_next    = byte_index;
    bit_index_next     = bit_index;
    receive_shift_next = receive_shift;
    captured_next      = captured;
    start              = 1'b0;
    start_kind         = req_type[1:0];
    cmd                = 1'b0;
    done               = 1'b0;

    case (req_type)
      gpsp_pkg::REQ_POLL_TICK: begin
        start = poll_enable && !frame_active;
      end
      gpsp_pkg::REQ_ENTER_CFG, gpsp_pkg::REQ_EXIT_CFG, gpsp_pkg::REQ_SET_ANALOG: begin
        start = !frame_active;
      end
      gpsp_pkg::REQ_BIT_SLOT: begin
        if (frame_active) begin
          cmd                = cur_byte[bit_index];
          receive_shift_next = {data_in, receive_shift[7:1]};
          if (bit_index == 3'd7) begin
            bit_index_next  = 3'd0;
            byte_index_next = bi_inc;
            if (frame_kind == gpsp_pkg::KIND_POLL && bi >= gpsp_pkg::FIRST_STORED) begin
              captured_next[slot[2:0]] = receive_shift_next;
            end
            if (bi_inc >= gpsp_pkg::frame_len(frame_kind)) begin
              frame_active_next = 1'b0;
              byte_index_next   = 4'd0;
              done              = 1'b1;
            end
          end else begin
            bit_index_next = bit_index + 3'd1;
          end
        end
      end
      gpsp_pkg::REQ_RESET_STATUS: begin
        captured_next = gpsp_pkg::captured_reset();
      end
      default: begin
      end
    endcase

    if (start) begin
      frame_active_next  = 1'b1;
      frame_kind_next    = start_kind;
      byte_index_next    = 4'd0;
      bit_index_next     = 3'd0;
      receive_shift_next = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_kind    <= gpsp_pkg::KIND_POLL;
      frame_active  <= 1'b0;
      byte_index    <= 4'd0;
      bit_index     <= 3'd0;
      receive_shift <= 8'd0;
      captured      <= gpsp_pkg::captured_reset();
    end else if (accept) begin
      frame_kind    <= frame_kind_next;
      frame_active  <= frame_active_next;
      byte_index    <= byte_index_next;
      bit_index     <= bit_index_next;
      receive_shift <= receive_shift_next;
      captured      <= captured_next;
    end
  end

  always_comb begin
    result.att_level  = !frame_active_next;
    result.cmd_bit    = cmd;
    result.busy_res   = frame_active_next;
    result.frame_done = done;
    result.captured   = captured_next;
  end

endmodule

### rtl/core/gpsp_out_buffer.sv
// ----------------------------------------------------------------------------
// gpsp_out_buffer
// Two-entry result queue between the frame engine and the output channel.
// ----------------------------------------------------------------------------
module gpsp_out_buffer #(
  parameter int unsigned DEPTH = gpsp_pkg::OUT_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  gpsp_pkg::result_t wr_data,
  input  logic              rd_en,
  output gpsp_pkg::result_t rd_data,
  output logic              full,
  output logic              not_empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  gpsp_pkg::result_t mem [DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [CW-1:0]     count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign rd_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/core/gamepad_serial_poll_master_unit.sv
// ----------------------------------------------------------------------------
// gamepad_serial_poll_master_unit
// Master side of a gamepad serial link: frame sequencing, bit exchange and
// capture of button and stick bytes.
// ----------------------------------------------------------------------------
//  channel | handshake             | word
//  --------+-----------------------+-------------------------------------------
//  in      | in_valid / in_stall   | req_type, data_in
//  out     | out_valid / out_stall | att_level .. frame_done, six captured bytes
//  cfg     | cfg_valid / cfg_ready | cfg_data (poll_enable)
//
// One word per cycle while in_stall is low; a word's result is queued when it is taken.
// Two-entry result queue; in_stall rises only when both entries wait.
// cfg_ready is always high.
// rst is synchronous; it clears the frame state and restores captured bytes.
// ----------------------------------------------------------------------------
module gamepad_serial_poll_master_unit #(
  parameter int unsigned OUT_DEPTH = gpsp_pkg::OUT_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] req_type,
  input  logic       data_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       att_level,
  output logic       cmd_bit,
  output logic       busy_res,
  output logic       frame_done,
  output logic [7:0] buttons_low,
  output logic [7:0] buttons_high,
  output logic [7:0] right_x,
  output logic [7:0] right_y,
  output logic [7:0] left_x,
  output logic [7:0] left_y,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);

  logic              poll_enable;
  logic              accept;
  logic              full;
  gpsp_pkg::result_t eng_result;
  gpsp_pkg::result_t q_result;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign accept    = in_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      poll_enable <= cfg_data;
    end
  end

  gpsp_frame_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .req_type    (req_type),
    .data_in     (data_in),
    .poll_enable (poll_enable),
    .result      (eng_result)
  );

  gpsp_out_buffer #(
    .DEPTH (OUT_DEPTH)
  ) u_out_buffer (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (accept),
    .wr_data   (eng_result),
    .rd_en     (out_valid && !out_stall),
    .rd_data   (q_result),
    .full      (full),
    .not_empty (out_valid)
  );

  assign att_level    = q_result.att_level;
  assign cmd_bit      = q_result.cmd_bit;
  assign busy_res     = q_result.busy_res;
  assign frame_done   = q_result.frame_done;
  assign buttons_low  = q_result.captured[0];
  assign buttons_high = q_result.captured[1];
  assign right_x      = q_result.captured[2];
  assign right_y      = q_result.captured[3];
  assign left_x       = q_result.captured[4];
  assign left_y       = q_result.captured[5];

endmodule

### test/gamepad_serial_poll_master_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gamepad_serial_poll_master_unit_tb
// Drives request and bit-slot words into the poll master and keeps a local
// model of the frame sequencer and the captured pad bytes. Every result word
// is checked field by field against the model, in order. Covers the idle
// request cases, starts while busy and a status reset in mid-frame. The
// random traffic is mostly whole frames with random pad data, with noise and
// cut-short frames mixed in. The poll enable is switched between phases.
// Bursty input, random output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module gamepad_serial_poll_master_unit_tb;

  localparam gpsp_pkg::req_t REQ_UNUSED_6 = 3'd6;
  localparam gpsp_pkg::req_t REQ_UNUSED_7 = 3'd7;
  localparam int HOLD_CYCLES = 80;
  localparam int CYCLE_LIMIT = 200000;

  localparam logic [8:0][7:0] FRAME_POLL =
    {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h42, 8'h01};
  localparam logic [8:0][7:0] FRAME_ENTER =
    {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h43, 8'h01};
  localparam logic [8:0][7:0] FRAME_EXIT =
    {8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h00, 8'h00, 8'h43, 8'h01};
  localparam logic [8:0][7:0] FRAME_ANALOG =
    {8'h00, 8'h00, 8'h00, 8'h00, 8'h03, 8'h01, 8'h00, 8'h44, 8'h01};

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_stall;
  gpsp_pkg::req_t req_type = gpsp_pkg::REQ_POLL_TICK;
  logic           data_in = 1'b0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  logic           att_level;
  logic           cmd_bit;
  logic           busy_res;
  logic           frame_done;
  logic [7:0]     buttons_low;
  logic [7:0]     buttons_high;
  logic [7:0]     right_x;
  logic [7:0]     right_y;
  logic [7:0]     left_x;
  logic [7:0]     left_y;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic           cfg_data = 1'b0;

  gamepad_serial_poll_master_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .data_in(data_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .att_level(att_level),
    .cmd_bit(cmd_bit),
    .busy_res(busy_res),
    .frame_done(frame_done),
    .buttons_low(buttons_low),
    .buttons_high(buttons_high),
    .right_x(right_x),
    .right_y(right_y),
    .left_x(left_x),
    .left_y(left_y),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state
  logic                poll_en;
  gpsp_pkg::kind_t     mdl_kind;
  logic                mdl_active;
  logic [3:0]          mdl_byte;
  logic [2:0]          mdl_bit;
  logic [7:0]          mdl_shift;
  gpsp_pkg::captured_t mdl_captured;

  gpsp_pkg::result_t pad_results_q[$];
  int mismatch_count = 0;
  int results_checked = 0;
  int words_sent = 0;
  int frames_done = 0;
  int polls_done = 0;
  int cfg_writes = 0;
  int cycle_count = 0;
  int burst_left = 0;
  bit idle_enabled = 1'b1;
  logic hold_active = 1'b0;
  event hold_off_ev;

  function automatic gpsp_pkg::captured_t idle_captured();
    gpsp_pkg::captured_t c;
    c[0] = 8'hFF;
    c[1] = 8'hFF;
    c[2] = 8'd128;
    c[3] = 8'd128;
    c[4] = 8'd128;
    c[5] = 8'd128;
    return c;
  endfunction

  function automatic int frame_length(input gpsp_pkg::kind_t k);
    return (k == gpsp_pkg::KIND_ENTER_CFG) ? 5 : 9;
  endfunction

  function automatic void open_frame(input gpsp_pkg::kind_t k);
    if (!mdl_active) begin
      mdl_active = 1'b1;
      mdl_kind = k;
      mdl_byte = 4'd0;
      mdl_bit = 3'd0;
      mdl_shift = 8'h00;
    end
  endfunction

  function automatic void predict_word(input gpsp_pkg::req_t req, input logic din);
    gpsp_pkg::result_t r;
    logic [8:0][7:0] frame_bytes;
    r.cmd_bit = 1'b0;
    r.frame_done = 1'b0;
    case (req)
      gpsp_pkg::REQ_POLL_TICK: if (poll_en) open_frame(gpsp_pkg::KIND_POLL);
      gpsp_pkg::REQ_ENTER_CFG: open_frame(gpsp_pkg::KIND_ENTER_CFG);
      gpsp_pkg::REQ_EXIT_CFG: open_frame(gpsp_pkg::KIND_EXIT_CFG);
      gpsp_pkg::REQ_SET_ANALOG: open_frame(gpsp_pkg::KIND_SET_ANALOG);
      gpsp_pkg::REQ_BIT_SLOT: begin
        if (mdl_active) begin
          case (mdl_kind)
            gpsp_pkg::KIND_POLL: frame_bytes = FRAME_POLL;
            gpsp_pkg::KIND_ENTER_CFG: frame_bytes = FRAME_ENTER;
            gpsp_pkg::KIND_EXIT_CFG: frame_bytes = FRAME_EXIT;
            default: frame_bytes = FRAME_ANALOG;
          endcase
          r.cmd_bit = frame_bytes[mdl_byte][mdl_bit];
          mdl_shift = {din, mdl_shift[7:1]};
          if (mdl_bit == 3'd7) begin
            mdl_bit = 3'd0;
            if (mdl_kind == gpsp_pkg::KIND_POLL && mdl_byte >= 4'd3)
              mdl_captured[3'(mdl_byte - 4'd3)] = mdl_shift;
            if (int'(mdl_byte) + 1 >= frame_length(mdl_kind)) begin
              mdl_active = 1'b0;
              mdl_byte = 4'd0;
              r.frame_done = 1'b1;
              frames_done++;
              if (mdl_kind == gpsp_pkg::KIND_POLL) polls_done++;
            end else begin
              mdl_byte = mdl_byte + 4'd1;
            end
          end else begin
            mdl_bit = mdl_bit + 3'd1;
          end
        end
      end
      gpsp_pkg::REQ_RESET_STATUS: mdl_captured = idle_captured();
      default: ;
    endcase
    r.att_level = ~mdl_active;
    r.busy_res = mdl_active;
    r.captured = mdl_captured;
    pad_results_q.push_back(r);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("word %0d %s got %0h want %0h",
                                results_checked, name, got, want));
  endtask

  // check each result word
  always @(posedge clk) begin
    gpsp_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pad_results_q.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        want = pad_results_q.pop_front();
        check_field("att_level", 8'(att_level), 8'(want.att_level));
        check_field("cmd_bit", 8'(cmd_bit), 8'(want.cmd_bit));
        check_field("busy_res", 8'(busy_res), 8'(want.busy_res));
        check_field("frame_done", 8'(frame_done), 8'(want.frame_done));
        check_field("buttons_low", buttons_low, want.captured[0]);
        check_field("buttons_high", buttons_high, want.captured[1]);
        check_field("right_x", right_x, want.captured[2]);
        check_field("right_y", right_y, want.captured[3]);
        check_field("left_x", left_x, want.captured[4]);
        check_field("left_y", left_y, want.captured[5]);
      end
      results_checked++;
    end
  end

  // output stall pattern
  int stall_pct = 0;
  int stall_mode_left = 0;
  always @(posedge clk) begin
    if (stall_mode_left == 0) begin
      stall_mode_left = $urandom_range(64, 16);
      case ($urandom_range(3))
        0: stall_pct = 0;
        1: stall_pct = 20;
        2: stall_pct = 50;
        default: stall_pct = 85;
      endcase
    end else begin
      stall_mode_left = stall_mode_left - 1;
    end
    out_stall <= hold_active || ($urandom_range(99) < stall_pct);
  end

  // long output hold-off
  always begin
    @(hold_off_ev);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("gamepad_serial_poll_master_unit_tb: done, errors");
      $finish;
    end
  end

  task automatic send_word(input gpsp_pkg::req_t req, input logic din);
    int gap;
    if (idle_enabled) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(24, 1);
        gap = $urandom_range(6, 1);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left--;
    end
    in_valid <= 1'b1;
    req_type <= req;
    data_in <= din;
    do @(posedge clk); while (in_stall);
    predict_word(req, din);
    words_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pad_results_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_poll_enable(input logic value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    poll_en = value;
    cfg_writes++;
  endtask

  task automatic test_idle_requests();
    write_poll_enable(1'b0);
    send_word(gpsp_pkg::REQ_POLL_TICK, 1'b1);
    send_word(gpsp_pkg::REQ_BIT_SLOT, 1'b1);
    send_word(gpsp_pkg::REQ_BIT_SLOT, 1'b0);
    send_word(REQ_UNUSED_6, 1'b1);
    send_word(REQ_UNUSED_7, 1'b0);
    send_word(gpsp_pkg::REQ_RESET_STATUS, 1'b1);
  endtask

  task automatic test_start_while_busy();
    send_word(gpsp_pkg::REQ_ENTER_CFG, 1'b0);
    send_word(gpsp_pkg::REQ_EXIT_CFG, 1'b1);
    send_word(gpsp_pkg::REQ_SET_ANALOG, 1'b0);
    send_word(gpsp_pkg::REQ_POLL_TICK, 1'b1);
    send_word(gpsp_pkg::REQ_BIT_SLOT, 1'b1);
    send_word(gpsp_pkg::REQ_BIT_SLOT, 1'b0);
    send_word(gpsp_pkg::REQ_RESET_STATUS, 1'b0);
    send_word(REQ_UNUSED_7, 1'b1);
    send_word(gpsp_pkg::REQ_BIT_SLOT, 1'b1);
    send_word(gpsp_pkg::REQ_BIT_SLOT, 1'b1);
    send_word(gpsp_pkg::REQ_ENTER_CFG, 1'b1);
  endtask

  task automatic test_output_hold();
    write_poll_enable(1'b1);
    idle_enabled = 1'b0;
    -> hold_off_ev;
    send_word(gpsp_pkg::REQ_POLL_TICK, 1'b0);
    repeat (40) send_word(gpsp_pkg::REQ_BIT_SLOT, 1'($urandom_range(1)));
    idle_enabled = 1'b1;
  endtask

  task automatic run_frame_traffic(input int n_words);
    int target;
    int slots;
    int s;
    gpsp_pkg::req_t start_req;
    gpsp_pkg::kind_t k;
    logic [7:0] pad_byte;
    target = words_sent + n_words;
    while (words_sent < target) begin
      idle_enabled = ($urandom_range(3) != 0);
      case ($urandom_range(9))
        0, 1, 2, 3: start_req = gpsp_pkg::REQ_POLL_TICK;
        4, 5: start_req = gpsp_pkg::REQ_ENTER_CFG;
        6, 7: start_req = gpsp_pkg::REQ_EXIT_CFG;
        default: start_req = gpsp_pkg::REQ_SET_ANALOG;
      endcase
      k = gpsp_pkg::kind_t'(start_req[1:0]);
      send_word(start_req, 1'($urandom_range(1)));
      slots = frame_length(k) * 8;
      if ($urandom_range(9) == 0) slots = $urandom_range(slots - 1);
      if ($urandom_range(9) == 0) slots += $urandom_range(8);
      for (s = 0; s < slots && words_sent < target; s++) begin
        if (s % 8 == 0) begin
          case ($urandom_range(5))
            0: pad_byte = 8'h00;
            1: pad_byte = 8'hFF;
            default: pad_byte = 8'($urandom_range(255));
          endcase
        end
        if ($urandom_range(19) == 0)
          send_word(gpsp_pkg::req_t'($urandom_range(7)), 1'($urandom_range(1)));
        send_word(gpsp_pkg::REQ_BIT_SLOT, pad_byte[s % 8]);
      end
    end
    idle_enabled = 1'b1;
  endtask

  initial begin
    poll_en = 1'b0;
    mdl_kind = gpsp_pkg::KIND_POLL;
    mdl_active = 1'b0;
    mdl_byte = 4'd0;
    mdl_bit = 3'd0;
    mdl_shift = 8'h00;
    mdl_captured = idle_captured();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_requests();
    test_start_while_busy();
    test_output_hold();
    run_frame_traffic(300);
    write_poll_enable(1'b0);
    run_frame_traffic(200);
    write_poll_enable(1'b1);
    run_frame_traffic(250);

    wait_drained();
    repeat (8) @(posedge clk);
    if (pad_results_q.size() != 0)
      report_mismatch($sformatf("%0d result words never came", pad_results_q.size()));

    $display("covered %0d words, %0d results, %0d config writes", words_sent,
             results_checked, cfg_writes);
    $display("frames completed %0d, of them poll frames %0d", frames_done, polls_done);
    if (mismatch_count == 0)
      $display("gamepad_serial_poll_master_unit_tb: done, clean");
    else
      $display("gamepad_serial_poll_master_unit_tb: done, errors");
    $finish;
  end

endmodule

### gamepad_serial_poll_master_unit.f
rtl/core/gpsp_pkg.sv
rtl/core/gpsp_frame_engine.sv
rtl/core/gpsp_out_buffer.sv
rtl/core/gamepad_serial_poll_master_unit.sv
test/gamepad_serial_poll_master_unit_tb.sv
